[hw/rtl/edc_pkg.sv]
// Shared types for the eta/duration converter: controller states,
// controller-to-datapath command word, datapath status, register indexes.
// No dependencies.
`timescale 1ns / 1ps

package edc_pkg;

	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_DURATION = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION    = 1'd1;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_PREP = 6'b000010,
		S_MUL  = 6'b000100,
		S_CHK  = 6'b001000,
		S_DIV  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	typedef struct packed {
		logic load;      // capture input word
		logic prep;      // apply first flag, form remaining time
		logic mul;       // encode: scale remaining time by eta
		logic chk;       // decode: range checks, divider init
		logic div_step;  // decode: one quotient bit
		logic fin;       // load result register, grow total
	} cmd_t;

	typedef struct packed {
		logic div_last;  // final quotient bit this cycle
	} stat_t;

endpackage

[hw/rtl/edc_dp.sv]
// Datapath of the eta/duration converter: running total, multiplier,
// restoring divider and result register.
// Depends on edc_pkg.
`timescale 1ns / 1ps

module edc_dp #(
	parameter int DURATION_BITS = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  edc_pkg::cmd_t       cmd,
	output edc_pkg::stat_t      status,
	input  logic                direction,
	input  logic [31:0]         max_duration,
	input  logic [31:0]         sample,
	input  logic                first,
	output logic [31:0]         value,
	output logic                error
);

	localparam int DB = DURATION_BITS;
	localparam int FB = FRACTION_BITS;
	localparam int RW = (DURATION_BITS < 32) ? DURATION_BITS : 32;
	localparam int PW = RW + FB + 1;
	localparam int CW = $clog2(FRACTION_BITS);
	localparam logic [FB:0] ETA_ONE = {1'b1, {FB{1'b0}}};

	logic [31:0]   sample_q;
	logic          first_q;
	logic [DB-1:0] total_q;
	logic [RW-1:0] rem_q;
	logic [FB:0]   eta_q;
	logic [RW-1:0] enc_val_q;
	logic          spec_q;
	logic          err_q;
	logic [RW-1:0] r_q;
	logic [FB-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   value_q;
	logic          error_q;

	logic [DB-1:0] total_eff;
	logic [DB-1:0] budget_ext;
	logic [RW-1:0] rem_n;
	logic [FB:0]   eta_n;
	logic [RW-1:0] dur;
	logic [PW-1:0] prod;
	logic [RW:0]   r2;
	logic [RW:0]   den;
	logic          ge;
	logic [RW-1:0] r_n;
	logic [RW-1:0] addend;
	logic [DB:0]   sum;
	logic [DB-1:0] total_sat;

	assign total_eff  = first_q ? '0 : total_q;
	assign budget_ext = DB'(max_duration[RW-1:0]);
	// remaining time clamps at zero once the total reaches the budget
	assign rem_n = (budget_ext > total_eff) ? RW'(budget_ext - total_eff) : '0;
	assign eta_n = (sample_q > 32'(ETA_ONE)) ? ETA_ONE : sample_q[FB:0];
	assign dur   = sample_q[RW-1:0];

	// eta <= 1.0, so the scaled product never exceeds the remaining time
	assign prod = PW'(rem_q) * PW'(eta_q);

	assign r2  = {r_q, 1'b0};
	assign den = {1'b0, rem_q};
	assign ge  = (r2 >= den);
	assign r_n = ge ? RW'(r2 - den) : r2[RW-1:0];

	assign addend    = direction ? dur : enc_val_q;
	assign sum       = {1'b0, total_q} + (DB+1)'(addend);
	assign total_sat = sum[DB] ? '1 : sum[DB-1:0];

	assign status.div_last = (cnt_q == CW'(FB - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			cnt_q   <= '0;
		end else begin
			if (cmd.prep && first_q) begin
				total_q <= '0;
			end else if (cmd.fin) begin
				total_q <= total_sat;
			end
			if (cmd.chk) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sample;
			first_q  <= first;
		end
		if (cmd.prep) begin
			rem_q <= rem_n;
			eta_q <= eta_n;
		end
		if (cmd.mul) begin
			enc_val_q <= prod[RW+FB-1:FB];
		end
		if (cmd.chk) begin
			spec_q <= (rem_q == '0) || (dur >= rem_q);
			err_q  <= (rem_q == '0) || (dur > rem_q);
			// special cases still run the divide: a zero dividend keeps it harmless
			r_q    <= ((rem_q == '0) || (dur >= rem_q)) ? '0 : dur;
			quo_q  <= '0;
		end else if (cmd.div_step) begin
			r_q   <= r_n;
			quo_q <= {quo_q[FB-2:0], ge};
		end
		if (cmd.fin) begin
			if (direction) begin
				value_q <= spec_q ? 32'(ETA_ONE) : 32'(quo_q);
			end else begin
				value_q <= 32'(enc_val_q);
			end
			error_q <= direction & err_q;
		end
	end

	assign value = value_q;
	assign error = error_q;

`ifndef ASSERT_OFF
	a_enc_le_rem: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.mul) |-> enc_val_q <= rem_q)
		else $error("encoded duration exceeds remaining time");

	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> total_q >= $past(total_q))
		else $error("running total shrank on result");

	a_div_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |=> r_q < rem_q || rem_q == '0)
		else $error("divider partial remainder out of range");
`endif

endmodule

[hw/rtl/edc_ctrl.sv]
// Controller of the eta/duration converter: sequences one word through
// prepare, multiply or divide, and the output register handshake.
// Depends on edc_pkg.
`timescale 1ns / 1ps

module edc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  logic            direction,
	input  edc_pkg::stat_t  status,
	output edc_pkg::cmd_t   cmd
);

	edc_pkg::state_t state_q;
	edc_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != edc_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			edc_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = edc_pkg::S_PREP;
				end
			end
			edc_pkg::S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = direction ? edc_pkg::S_CHK : edc_pkg::S_MUL;
			end
			edc_pkg::S_MUL: begin
				cmd.mul = 1'b1;
				state_d = edc_pkg::S_FIN;
			end
			edc_pkg::S_CHK: begin
				cmd.chk = 1'b1;
				state_d = edc_pkg::S_DIV;
			end
			edc_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = edc_pkg::S_FIN;
				end
			end
			edc_pkg::S_FIN: begin
				// hold until the result register can take the word
				if (out_free) begin
					cmd.fin = 1'b1;
					state_d = edc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = edc_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= edc_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_accept_to_prep: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == edc_pkg::S_PREP)
		else $error("accepted word did not enter prepare");

	a_fin_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> !out_valid_q || !out_stall)
		else $error("result register overwritten while stalled");

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == edc_pkg::S_FIN && out_valid_q && out_stall
		|=> state_q == edc_pkg::S_FIN)
		else $error("finish left while output blocked");
`endif

endmodule

[hw/rtl/eta_duration_convert_core.sv]
// Top level of the eta/duration converter: configuration registers,
// controller and datapath.
// Depends on edc_pkg, edc_ctrl, edc_dp.
`timescale 1ns / 1ps

// Converts vector elements between Q1.FRACTION_BITS fractions (eta) and
// durations, stick-breaking style. direction 0: value = floor(remaining *
// eta), eta saturated at 1.0. direction 1: value = floor(duration * 2^F /
// remaining), or 1.0 with error set when no time is left or the duration
// exceeds it. The running total grows by the duration either way and is
// cleared by first. One word is in flight at a time: an encode steps
// through capture, prepare, one multiply and finish; a decode steps through
// capture, prepare, range check, the restoring divider that produces one
// quotient bit per cycle, and finish. A result waiting in the output
// register does not block the next input word. Configuration is to be
// written only while the block is idle; the block does not enforce this.
module eta_duration_convert_core #(
	parameter int DURATION_BITS = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [edc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [31:0]                     sample,
	input  logic                            first,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [31:0]                     value,
	output logic                            error
);

	logic [31:0]    max_duration_q;
	logic           direction_q;
	edc_pkg::cmd_t  cmd;
	edc_pkg::stat_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_duration_q <= '0;
			direction_q    <= 1'b0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				edc_pkg::REG_MAX_DURATION: max_duration_q <= cfg_data;
				edc_pkg::REG_DIRECTION:    direction_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	edc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.direction (direction_q),
		.status    (status),
		.cmd       (cmd)
	);

	edc_dp #(
		.DURATION_BITS (DURATION_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.direction    (direction_q),
		.max_duration (max_duration_q),
		.sample       (sample),
		.first        (first),
		.value        (value),
		.error        (error)
	);

endmodule
